// File: hdl/sha256_pkg.sv
// Package for the SHA-256 byte stream hasher: round constants, initial hash
// values, controller/datapath command struct, and round functions.
// No dependencies.
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos = 56;
  localparam int unsigned Rounds = 64;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Buffer write source selection.
  typedef enum logic [1:0] {
    WR_DATA = 2'd0,
    WR_PAD  = 2'd1,
    WR_ZERO = 2'd2,
    WR_LEN  = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic        buf_we;     // write one buffer byte
    wr_sel_t     wr_sel;
    logic [5:0]  wr_addr;
    logic        count_bits; // add 8 to bit count
    logic        load_work;  // copy hash state into working vars
    logic        round_en;   // run one round
    logic [5:0]  round_idx;
    logic        fold;       // add working vars into hash state
    logic        restart;    // initial hash values, bit count zero
    logic [2:0]  out_idx;    // digest word selection
  } dp_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: hdl/sha256_if.sv
// Valid/ready channel interfaces for the hasher's input and digest beats.
// No dependencies.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: joins controller and datapath.
// Depends on sha256_pkg, sha256_if, sha256_ctrl and sha256_datapath.
//
// Usage: the in channel carries one beat per message byte (kind = 0) or a
// finish beat (kind = 1). Data bytes are taken one per cycle until the
// 64-byte buffer fills; then the block loads the working variables, runs 64
// rounds and folds them into the hash state, with in_ready low. The single
// round unit thus takes no new bytes while a block is being compressed.
// A finish writes the pad byte, then fills zeros and the 64-bit bit count
// one byte per cycle, running one compression, or two when more than 55
// bytes were held. It then shows eight digest beats on the out channel,
// word 0 first, last_word high on word 7. If the receiver stalls, the
// current word holds and no new input is taken until all eight are gone.
// After the last beat the hash state and bit count return to the initial
// values, ready for the next message. Reset (synchronous, rst_n low) does
// the same and empties the buffer; buffer contents themselves are not
// cleared since every byte is written before it is read.
module sha256_byte_stream_hasher (
  input logic          clk,
  input logic          rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  sha256_pkg::dp_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd)
  );

  sha256_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .digest_word (out_ch.digest_word)
  );

endmodule

// File: hdl/sha256_datapath.sv
// Datapath: 64-byte block buffer, message schedule window, round unit,
// hash state and bit counter. Depends on sha256_pkg.
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  output logic [31:0]          digest_word
);

  // The block buffer is held as sixteen big-endian words, written a byte lane at a time.
  logic [31:0] mem_r [16];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [63:0] bits_r;
  logic [7:0]  wr_data;
  logic [31:0] t1, t2;
  logic [5:0]  ri;

  always_comb begin
    unique case (cmd.wr_sel)
      sha256_pkg::WR_DATA: wr_data = data_byte;
      sha256_pkg::WR_PAD:  wr_data = sha256_pkg::PadByte;
      sha256_pkg::WR_ZERO: wr_data = 8'h00;
      sha256_pkg::WR_LEN:  wr_data = bits_r[8 * (7 - cmd.wr_addr[2:0]) +: 8];
      default:             wr_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      mem_r[cmd.wr_addr[5:2]][8 * (3 - cmd.wr_addr[1:0]) +: 8] <= wr_data;
    end
  end

  // Schedule word for this round: first 16 straight from the buffer,
  // later ones from the sliding window.
  assign ri = cmd.round_idx;
  always_comb begin
    if (ri < 6'd16) begin
      w_nxt = mem_r[ri[3:0]];
    end else begin
      w_nxt = w_r[0] + sha256_pkg::ssig0(w_r[1]) + w_r[9] + sha256_pkg::ssig1(w_r[14]);
    end
    t1 = v_r[7] + sha256_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha256_pkg::RoundK[ri] + w_nxt;
    t2 = sha256_pkg::bsig0(v_r[0])
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_nxt;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitHash[i];
      bits_r <= 64'd0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.count_bits) begin
        bits_r <= bits_r + 64'd8;
      end
    end
  end

  assign digest_word = h_r[cmd.out_idx];

endmodule

// File: hdl/sha256_ctrl.sv
// Controller: accepts beats, sequences padding, 64-round compressions and
// digest output. Depends on sha256_pkg and sha256_if.
module sha256_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  sha256_in_if.sink           in_ch,
  sha256_out_if.source        out_ch,
  output sha256_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t     state_r;
  logic [5:0] fill_r;     // bytes held, also pad pointer
  logic [5:0] round_r;
  logic       final_r;    // current compression is the last one
  logic [2:0] idx_r;
  logic       out_valid_r;
  // Set while a finish is being processed, so the fold after the first of two
  // padding blocks goes on to the length block instead of back to idle.
  logic       padding_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.word_index = idx_r;
  assign out_ch.last_word = (idx_r == 3'd7);

  always_comb begin
    cmd = '0;
    cmd.wr_addr = fill_r;
    cmd.round_idx = round_r;
    cmd.out_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd.buf_we = 1'b1;
          if (!in_ch.kind) begin
            cmd.wr_sel = sha256_pkg::WR_DATA;
            cmd.count_bits = 1'b1;
          end else begin
            cmd.wr_sel = sha256_pkg::WR_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.buf_we = 1'b1;
        cmd.wr_sel = (final_r && fill_r >= 6'(sha256_pkg::LengthPos)) ?
                     sha256_pkg::WR_LEN : sha256_pkg::WR_ZERO;
      end
      S_LOAD:  cmd.load_work = 1'b1;
      S_ROUND: cmd.round_en = 1'b1;
      S_FOLD:  cmd.fold = 1'b1;
      S_EMIT:  cmd.restart = out_ch.ready && (idx_r == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= 6'd0;
      round_r <= 6'd0;
      final_r <= 1'b0;
      idx_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            fill_r <= fill_r + 6'd1;
            if (!in_ch.kind) begin
              final_r <= 1'b0;
              if (fill_r == 6'd63) state_r <= S_LOAD;
            end else begin
              // Length fits after the pad byte only if at most 55 bytes held.
              final_r <= (fill_r < 6'(sha256_pkg::LengthPos));
              state_r <= (fill_r == 6'd63) ? S_LOAD : S_PAD;
            end
          end
        end
        S_PAD: begin
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'd63) state_r <= S_LOAD;
        end
        S_LOAD: begin
          round_r <= 6'd0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (final_r) begin
            state_r <= S_EMIT;
            idx_r <= 3'd0;
            out_valid_r <= 1'b1;
          end else if (fill_r != 6'd0 || !padding_r) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_PAD;
            final_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              out_valid_r <= 1'b0;
              state_r <= S_IDLE;
              final_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      padding_r <= 1'b0;
    end else if (state_r == S_IDLE && in_ch.valid) begin
      padding_r <= in_ch.kind;
    end else if (state_r == S_EMIT && out_ch.ready && idx_r == 3'd7) begin
      padding_r <= 1'b0;
    end
  end

endmodule

// File: bench/tb_sha256_byte_stream_hasher.sv
// Self-checking bench for the SHA-256 byte stream hasher: drives message bytes and
// finish beats, predicts each digest word and compares it with what the block emits.
// Depends on sha256_pkg, sha256_if and the hasher RTL.
module tb_sha256_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {KIND_DATA = 1'b0, KIND_FINISH = 1'b1} beat_kind_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_byte_stream_hasher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the hashing state.
  logic [31:0] hash_words [8];
  logic [7:0]  msg_block [64];
  int unsigned bytes_held;
  logic [63:0] msg_bits;

  digest_beat_t expected_words [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  // Idling knobs: percent of cycles each side idles, and the receiver hold-off.
  // A test asks for a hold-off by bumping the request count; the receiver counts it down.
  int unsigned send_gap_pct = 33;
  int unsigned recv_stall_pct = 33;
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_off_cycles = 0;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] sched [64];
    logic [31:0] wv [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) wv[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      t1 = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25))
         + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + sha256_pkg::RoundK[i] + sched[i];
      t2 = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22))
         + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
      wv[7] = wv[6]; wv[6] = wv[5]; wv[5] = wv[4]; wv[4] = wv[3] + t1;
      wv[3] = wv[2]; wv[2] = wv[1]; wv[1] = wv[0]; wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += wv[i];
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_words[i] = sha256_pkg::InitHash[i];
    bytes_held = 0;
    msg_bits = '0;
  endtask

  // Applies one accepted beat to the predictor; a finish queues eight digest words.
  task automatic hash_beat(beat_kind_t kind, logic [7:0] data_byte);
    int unsigned pos;
    digest_beat_t beat;
    if (kind == KIND_DATA) begin
      msg_bits += 64'd8;
      msg_block[bytes_held] = data_byte;
      bytes_held++;
      if (bytes_held == sha256_pkg::BlockBytes) begin
        compress_msg_block();
        bytes_held = 0;
      end
      return;
    end
    pos = bytes_held;
    msg_block[pos++] = sha256_pkg::PadByte;
    // Not enough room for the length field: pad out and compress an extra block.
    if (pos > sha256_pkg::LengthPos) begin
      while (pos < sha256_pkg::BlockBytes) msg_block[pos++] = 8'h00;
      compress_msg_block();
      pos = 0;
    end
    while (pos < sha256_pkg::LengthPos) msg_block[pos++] = 8'h00;
    for (int i = 0; i < 8; i++)
      msg_block[sha256_pkg::LengthPos + i] = msg_bits[63 - 8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++) begin
      beat.digest_word = hash_words[i];
      beat.word_index = 3'(i);
      beat.last_word = (i == 7);
      expected_words.push_back(beat);
    end
    restart_digest();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Sends one beat, honoring random sender gaps, and feeds the predictor on acceptance.
  // Valid stays up after the accepting edge; a gap or a drain wait drops it.
  task automatic send_beat(beat_kind_t kind, logic [7:0] data_byte);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data_byte <= data_byte;
    do @(posedge clk); while (!in_ch.ready);
    hash_beat(kind, data_byte);
  endtask

  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++) send_beat(KIND_DATA, 8'($urandom));
    send_beat(KIND_FINISH, 8'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls plus an optional long hold-off counted here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_requests;
      hold_off_cycles <= HoldOffCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: each accepted digest beat against the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_ch.digest_word, 32'h0);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_ch.digest_word, want.digest_word);
        if (out_ch.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_ch.word_index), 32'(want.word_index));
        if (out_ch.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_ch.last_word), 32'(want.last_word));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_sha256_byte_stream_hasher: FAIL");
      $finish;
    end
  end

  // Empty message, single bytes at both extremes, a three-byte message, and the finish byte ignored.
  task automatic test_directed();
    send_beat(KIND_FINISH, 8'hff);
    send_beat(KIND_DATA, 8'h00);
    send_beat(KIND_FINISH, 8'h00);
    send_beat(KIND_DATA, 8'hff);
    send_beat(KIND_FINISH, 8'h5a);
    send_beat(KIND_DATA, 8'h61);
    send_beat(KIND_DATA, 8'h62);
    send_beat(KIND_DATA, 8'h63);
    send_beat(KIND_FINISH, 8'ha5);
    wait_drained();
  endtask

  // Lengths around the padding boundaries: 55 fits one block, 56 and 63 need two, 64 full.
  task automatic test_pad_boundaries();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    wait_drained();
  endtask

  // Receiver holds off long while finishes pile up, so the block stalls its input.
  task automatic test_back_pressure();
    hold_off_requests++;
    send_gap_pct = 0;
    send_message(0);
    send_message(3);
    send_message(1);
    send_gap_pct = 33;
    wait_drained();
  endtask

  // Random messages, mostly short, with one run free of idling on either side.
  task automatic test_random_messages();
    int unsigned len;
    for (int m = 0; m < 8; m++) begin
      if (m == 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      if (m == 6) begin
        send_gap_pct = 33;
        recv_stall_pct = 33;
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(70) : $urandom_range(6);
      send_message(len);
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_DATA;
    in_ch.data_byte = 8'h00;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    restart_digest();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pad_boundaries();
    test_back_pressure();
    test_random_messages();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("tb_sha256_byte_stream_hasher: PASS");
    end else begin
      $display("tb_sha256_byte_stream_hasher: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sha256_pkg.sv
hdl/sha256_if.sv
hdl/sha256_datapath.sv
hdl/sha256_ctrl.sv
hdl/sha256_byte_stream_hasher.sv
bench/tb_sha256_byte_stream_hasher.sv
